// ----- rtl/fpvn_pkg.sv -----
// Shared types and constants for the fixed-point vector normalizer.
`timescale 1ns / 1ps
package fpvn_pkg;

  localparam int CompW    = 24;
  localparam int UnitW    = 20;
  localparam int SqW      = 32;
  localparam int RootW    = 16;
  localparam int SqrtCells = 16;
  localparam logic [SqW-1:0] SqrtTopBit = 32'h4000_0000;

  typedef struct packed {
    logic signed [CompW-1:0] z;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic [SqW-1:0] rem;
    logic [SqW-1:0] res;
  } sqrt_t;

endpackage

// ----- rtl/fpvn_sqrt_cell.sv -----
// One cell of the bit-by-bit square root chain: settles one root bit.
`timescale 1ns / 1ps
module fpvn_sqrt_cell
  import fpvn_pkg::*;
#(
  parameter int Idx = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t sq_i,
  input  vec_t  vec_i,
  output logic  valid_o,
  output sqrt_t sq_o,
  output vec_t  vec_o
);

  localparam logic [SqW-1:0] Bit = SqrtTopBit >> (2 * Idx);

  logic  valid_q;
  sqrt_t sq_d, sq_q;
  vec_t  vec_q;
  logic [SqW-1:0] trial;

  always_comb begin
    trial = sq_i.res + Bit;
    if (sq_i.rem >= trial) begin
      sq_d.rem = sq_i.rem - trial;
      sq_d.res = (sq_i.res >> 1) + Bit;
    end else begin
      sq_d.rem = sq_i.rem;
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      vec_q <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign vec_o   = vec_q;

endmodule

// ----- rtl/fpvn_div_cell.sv -----
// One cell of the restoring divider chain: settles one reciprocal bit.
`timescale 1ns / 1ps
module fpvn_div_cell
  import fpvn_pkg::*;
#(
  parameter int QW     = 25,
  parameter bit NumBit = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [RootW-1:0] root_i,
  input  logic [RootW-1:0] rem_i,
  input  logic [QW-1:0]    quo_i,
  input  vec_t             vec_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [RootW-1:0] rem_o,
  output logic [QW-1:0]    quo_o,
  output vec_t             vec_o
);

  logic             valid_q;
  logic [RootW-1:0] root_q, rem_d, rem_q;
  logic [QW-1:0]    quo_d, quo_q;
  vec_t             vec_q;
  logic [RootW:0]   shifted, diff;
  logic             take;

  always_comb begin
    shifted = {rem_i, NumBit};
    diff    = shifted - {1'b0, root_i};
    take    = (shifted >= {1'b0, root_i});
    rem_d   = take ? diff[RootW-1:0] : shifted[RootW-1:0];
    quo_d   = {quo_i[QW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      vec_q  <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign vec_o   = vec_q;

endmodule

// ----- rtl/fixed_point_vector_normalize.sv -----
// Throughput: one word per cycle; the pipeline only holds when the output word
// waits on m_axis_tready.
// Data runs through the 16 square root cells and the divider cells, one result bit per cell.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data regs keep.
`timescale 1ns / 1ps
module fixed_point_vector_normalize
  import fpvn_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // vec_x [23:0], vec_y [47:24], vec_z [71:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // unit_x [19:0], unit_y [39:20], unit_z [59:40], 0
);

  localparam int Half = FRAC_BITS / 2;
  localparam int Exp  = 2 * FRAC_BITS - Half;
  localparam int QW   = Exp + 1;
  localparam int PW   = CompW + QW + 1;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: input and squares
  logic v0_q;
  vec_t vec0_q;
  logic [2*CompW-1:0] sqx_q, sqy_q, sqz_q;
  vec_t vec_in;
  assign vec_in = vec_t'(s_axis_tdata);

  // stage 1: squared length
  logic v1_q;
  vec_t vec1_q;
  logic [SqW-1:0] sq1_q;
  logic [2*CompW+1:0] sum;
  assign sum = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec0_q <= vec_in;
      sqx_q  <= unsigned'((2*CompW)'(vec_in.x) * (2*CompW)'(vec_in.x));
      sqy_q  <= unsigned'((2*CompW)'(vec_in.y) * (2*CompW)'(vec_in.y));
      sqz_q  <= unsigned'((2*CompW)'(vec_in.z) * (2*CompW)'(vec_in.z));
      vec1_q <= vec0_q;
      sq1_q  <= sum[FRAC_BITS +: SqW];
    end
  end

  // square root chain
  logic  sv [SqrtCells+1];
  sqrt_t ss [SqrtCells+1];
  vec_t  svec [SqrtCells+1];
  assign sv[0]   = v1_q;
  assign ss[0]   = '{rem: sq1_q, res: '0};
  assign svec[0] = vec1_q;

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    fpvn_sqrt_cell #(.Idx(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sv[i]), .sq_i(ss[i]), .vec_i(svec[i]),
      .valid_o(sv[i+1]), .sq_o(ss[i+1]), .vec_o(svec[i+1])
    );
  end

  // divider chain: 2^Exp / root
  logic             dv [QW+1];
  logic [RootW-1:0] droot [QW+1];
  logic [RootW-1:0] drem [QW+1];
  logic [QW-1:0]    dquo [QW+1];
  vec_t             dvec [QW+1];
  assign dv[0]    = sv[SqrtCells];
  assign droot[0] = ss[SqrtCells].res[RootW-1:0];
  assign drem[0]  = '0;
  assign dquo[0]  = '0;
  assign dvec[0]  = svec[SqrtCells];

  for (genvar j = 0; j < QW; j++) begin : g_div
    fpvn_div_cell #(.QW(QW), .NumBit(j == 0)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[j]), .root_i(droot[j]), .rem_i(drem[j]), .quo_i(dquo[j]),
      .vec_i(dvec[j]),
      .valid_o(dv[j+1]), .root_o(droot[j+1]), .rem_o(drem[j+1]),
      .quo_o(dquo[j+1]), .vec_o(dvec[j+1])
    );
  end

  // products, then shift into the output word
  logic [QW-1:0] recip;
  assign recip = (droot[QW] == '0) ? '0 : dquo[QW];

  logic vp_q;
  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [QW:0] recip_s;
  assign recip_s = signed'({1'b0, recip});

  logic vo_q;
  logic [UnitW-1:0] ux_q, uy_q, uz_q;
  logic signed [PW-1:0] shx, shy, shz;
  assign shx = px_q >>> FRAC_BITS;
  assign shy = py_q >>> FRAC_BITS;
  assign shz = pz_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      vp_q <= dv[QW];
      vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= dvec[QW].x * recip_s;
      py_q <= dvec[QW].y * recip_s;
      pz_q <= dvec[QW].z * recip_s;
      ux_q <= shx[UnitW-1:0];
      uy_q <= shy[UnitW-1:0];
      uz_q <= shz[UnitW-1:0];
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {4'h0, uz_q, uy_q, ux_q};

  // zero root must give a zero reciprocal, whatever the divider chain says
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[QW] && droot[QW] == '0 |-> recip == '0)
    else $error("nonzero reciprocal for zero length");

  // reciprocal is the floor of 2^Exp / root
  a_recip_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[QW] && droot[QW] != '0 |->
      ({8'd0, recip} * {{(QW-RootW+8){1'b0}}, droot[QW]}) <= (64'd1 << Exp) &&
      ({8'd0, recip} + 1'b1) * {{(QW-RootW+8){1'b0}}, droot[QW]} > (64'd1 << Exp))
    else $error("reciprocal out of range");

  // root fits in 16 bits and the leftover stays within twice the root
  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv[SqrtCells] |-> ss[SqrtCells].res[SqW-1:RootW] == '0 &&
      {1'b0, ss[SqrtCells].rem} <= {ss[SqrtCells].res, 1'b0})
    else $error("square root overshoot");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule
